@@ rtl/core/ostt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ostt_pkg: shared types and constants for the one-shot timer table
// Request and result payload structs, request kind codes, table geometry.
// ----------------------------------------------------------------------------
package ostt_pkg;

	localparam int SLOTS   = 4;
	localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_SET   = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  timer_id;
		logic [31:0] delay_ms;
	} ostt_req_t;

	typedef struct packed {
		logic        fired;
		logic [7:0]  fired_id;
		logic        status;
		logic [31:0] now_ms;
		logic        last;
	} ostt_res_t;

endpackage

@@ rtl/core/one_shot_timer_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_table: millisecond counter with a table of one-shot timers
// Tick, set and clear requests; one slot is examined per cycle by a shared
// compare unit under a small sequencer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A tick, or a set or
// clear with a nonzero id, scans the table one slot per cycle through the
// single owner/deadline compare: busy stays high through S_SCAN and S_FINISH,
// and no new request is taken until it falls. An unused kind, or a set or
// clear with id zero, skips the scan: busy is high only while the request
// sits in S_FINISH. Results appear on res for exactly one cycle each,
// flagged by res_strobe; the receiver cannot hold them off and must take
// every one. A tick gives one result per expired timer (ascending slot
// order), or one result with fired low; set and clear give one result each.
// The final result of a request carries last and shows in the first cycle
// busy is low again.
module one_shot_timer_table
	import ostt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ostt_req_t req,
	output logic      busy,
	output logic      res_strobe,
	output ostt_res_t res
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t            state_q;
	logic [1:0]        kind_q;
	logic [7:0]        id_q;
	logic [31:0]       dur_q;
	logic [SLOT_IW-1:0] idx_q;
	logic [31:0]       ms_count_q;
	logic [7:0]        owner_q [SLOTS];
	logic [31:0]       deadline_q [SLOTS];
	logic              hit_q;
	logic [SLOT_IW-1:0] hit_idx_q;
	logic              emp_q;
	logic [SLOT_IW-1:0] emp_idx_q;
	logic              pend_q;
	logic [7:0]        pend_id_q;
	logic              res_strobe_q;
	ostt_res_t         res_q;

	logic [7:0]        cur_owner;
	logic              dl_match;
	logic              scan_end;
	logic              accept;
	logic [SLOT_IW-1:0] tgt_idx;
	logic              fin_fired;
	logic              set_full;

	assign accept    = start && (state_q == S_IDLE);
	assign cur_owner = owner_q[idx_q];
	assign dl_match  = (cur_owner != 8'd0) && (deadline_q[idx_q] == ms_count_q);
	assign scan_end  = (idx_q == SLOT_IW'(SLOTS - 1));
	assign tgt_idx   = hit_q ? hit_idx_q : emp_idx_q;
	assign fin_fired = (kind_q == KIND_TICK) && pend_q;
	assign set_full  = (kind_q == KIND_SET) && (id_q != 8'd0) && !hit_q && !emp_q;

	assign busy       = (state_q != S_IDLE);
	assign res_strobe = res_strobe_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ms_count_q   <= 32'd0;
			res_strobe_q <= 1'b0;
			pend_q       <= 1'b0;
			hit_q        <= 1'b0;
			emp_q        <= 1'b0;
			idx_q        <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				owner_q[i] <= 8'd0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					res_strobe_q <= 1'b0;
					if (accept) begin
						kind_q <= req.kind;
						id_q   <= req.timer_id;
						dur_q  <= (req.delay_ms == 32'd0) ? 32'd1 : req.delay_ms;
						idx_q  <= '0;
						hit_q  <= 1'b0;
						emp_q  <= 1'b0;
						pend_q <= 1'b0;
						if (req.kind == KIND_TICK) begin
							ms_count_q <= ms_count_q + 32'd1;
							state_q    <= S_SCAN;
						end else if ((req.kind == KIND_SET || req.kind == KIND_CLEAR)
								&& req.timer_id != 8'd0) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN: begin
					res_strobe_q <= (kind_q == KIND_TICK) && dl_match && pend_q;
					if (kind_q == KIND_TICK) begin
						if (dl_match) begin
							owner_q[idx_q] <= 8'd0;
							pend_q         <= 1'b1;
							pend_id_q      <= cur_owner;
							if (pend_q) begin
								res_q.fired    <= 1'b1;
								res_q.fired_id <= pend_id_q;
								res_q.status   <= 1'b0;
								res_q.now_ms   <= ms_count_q;
								res_q.last     <= 1'b0;
							end
						end
					end else begin
						if (!hit_q && cur_owner == id_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_q;
						end
						if (!emp_q && cur_owner == 8'd0) begin
							emp_q     <= 1'b1;
							emp_idx_q <= idx_q;
						end
					end
					if (scan_end) begin
						idx_q   <= '0;
						state_q <= S_FINISH;
					end else begin
						idx_q <= idx_q + SLOT_IW'(1);
					end
				end
				S_FINISH: begin
					res_strobe_q   <= 1'b1;
					res_q.fired    <= fin_fired;
					res_q.fired_id <= fin_fired ? pend_id_q : 8'd0;
					res_q.status   <= set_full;
					res_q.now_ms   <= ms_count_q;
					res_q.last     <= 1'b1;
					if (kind_q == KIND_SET && id_q != 8'd0) begin
						if (hit_q || emp_q) begin
							owner_q[tgt_idx]    <= id_q;
							deadline_q[tgt_idx] <= ms_count_q + dur_q;
						end
					end else if (kind_q == KIND_CLEAR && id_q != 8'd0) begin
						if (hit_q) begin
							owner_q[hit_idx_q] <= 8'd0;
						end
					end
					state_q <= S_IDLE;
				end
				default: begin
					res_strobe_q <= 1'b0;
					state_q      <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/ostt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ostt_checker: port-level checks for the one-shot timer table
// Watches request acceptance and result strobes; bound into one_shot_timer_table.
// ----------------------------------------------------------------------------
module ostt_checker
	import ostt_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      res_strobe,
	input ostt_res_t res
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted request");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && res.last |-> !busy)
		else $error("final result shown while still busy");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && !res.last |-> busy)
		else $error("non-final result outside a request");

	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && !res.fired |-> res.fired_id == 8'd0)
		else $error("fired_id nonzero with fired low");

	a_fire_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && res.fired |-> res.status == 1'b0)
		else $error("status set on expiry result");

endmodule

bind one_shot_timer_table ostt_checker u_ostt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.res_strobe (res_strobe),
	.res        (res)
);

@@ sim/one_shot_timer_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_table_tb: self-checking bench for the one-shot timer table
// Drives tick, set, clear and unused-kind requests: a directed opening, then
// random traffic in three sender-gap phases. A scoreboard keeps its own copy
// of the counter and slot table and compares every strobed result against it.
// ----------------------------------------------------------------------------
module one_shot_timer_table_tb
	import ostt_pkg::*;
;

	localparam logic [1:0]  KIND_UNUSED   = 2'd3;
	localparam int unsigned STALL_LIMIT   = 5000;
	localparam int unsigned RANDOM_ITEMS  = 188;

	class timer_table_scoreboard;
		logic [31:0] now_ms;
		logic [7:0]  owner [SLOTS];
		logic [31:0] deadline [SLOTS];
		ostt_res_t   expected_q [$];
		int unsigned mismatches;

		function new();
			now_ms = '0;
			mismatches = 0;
			for (int i = 0; i < SLOTS; i++) begin
				owner[i] = '0;
				deadline[i] = '0;
			end
		endfunction

		function int find_slot(logic [7:0] id);
			for (int i = 0; i < SLOTS; i++) begin
				if (owner[i] == id) begin
					return i;
				end
			end
			return -1;
		endfunction

		function void push_result(logic fired, logic [7:0] id, logic status, logic last);
			ostt_res_t r;
			r.fired = fired;
			r.fired_id = id;
			r.status = status;
			r.now_ms = now_ms;
			r.last = last;
			expected_q.push_back(r);
		endfunction

		function void note_request(ostt_req_t r);
			int          slot;
			int unsigned fired_count;
			logic [31:0] dur;
			logic        full;
			fired_count = 0;
			full = 1'b0;
			dur = (r.delay_ms == '0) ? 32'd1 : r.delay_ms;
			if (r.kind == KIND_TICK) begin
				now_ms = now_ms + 32'd1;
				for (int i = 0; i < SLOTS; i++) begin
					if (owner[i] != '0 && deadline[i] == now_ms) begin
						push_result(1'b1, owner[i], 1'b0, 1'b0);
						owner[i] = '0;
						fired_count++;
					end
				end
				if (fired_count == 0) begin
					push_result(1'b0, 8'h00, 1'b0, 1'b1);
				end else begin
					expected_q[expected_q.size() - 1].last = 1'b1;
				end
				return;
			end
			if (r.kind == KIND_SET && r.timer_id != '0) begin
				slot = find_slot(r.timer_id);
				if (slot < 0) begin
					slot = find_slot(8'h00);
				end
				if (slot < 0) begin
					full = 1'b1;
				end else begin
					owner[slot] = r.timer_id;
					deadline[slot] = now_ms + dur;
				end
			end else if (r.kind == KIND_CLEAR && r.timer_id != '0) begin
				slot = find_slot(r.timer_id);
				if (slot >= 0) begin
					owner[slot] = '0;
				end
			end
			push_result(1'b0, 8'h00, full, 1'b1);
		endfunction

		task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
			$display("%0t: mismatch on %s: got %0h, want %0h", $time, field, got, want);
			mismatches++;
		endtask

		task check_result(ostt_res_t got);
			ostt_res_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", {got.fired_id, got.now_ms[23:0]}, '0);
				return;
			end
			want = expected_q.pop_front();
			if (got.fired !== want.fired)
				report_mismatch("fired", 32'(got.fired), 32'(want.fired));
			if (got.fired_id !== want.fired_id)
				report_mismatch("fired_id", 32'(got.fired_id), 32'(want.fired_id));
			if (got.status !== want.status)
				report_mismatch("status", 32'(got.status), 32'(want.status));
			if (got.now_ms !== want.now_ms)
				report_mismatch("now_ms", got.now_ms, want.now_ms);
			if (got.last !== want.last)
				report_mismatch("last", 32'(got.last), 32'(want.last));
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	ostt_req_t req = '0;
	logic      busy;
	logic      res_strobe;
	ostt_res_t res;

	timer_table_scoreboard sb = new();
	int unsigned           stall_cycles = 0;

	one_shot_timer_table u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req),
		.busy       (busy),
		.res_strobe (res_strobe),
		.res        (res)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_strobe) begin
				sb.check_result(res);
			end
			if (start && !busy) begin
				sb.note_request(req);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || res_strobe) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic ostt_req_t make_req(logic [1:0] kind, logic [7:0] id, logic [31:0] dur);
		ostt_req_t r;
		r.kind = kind;
		r.timer_id = id;
		r.delay_ms = dur;
		return r;
	endfunction

	function automatic ostt_req_t random_request();
		ostt_req_t   r;
		int unsigned pick;
		int unsigned dsel;
		pick = $urandom_range(0, 99);
		dsel = $urandom_range(0, 9);
		if ($urandom_range(0, 99) < 85)
			r.timer_id = 8'($urandom_range(1, 6));
		else
			r.timer_id = 8'($urandom_range(1, 255));
		if (dsel < 7)
			r.delay_ms = $urandom_range(0, 6);
		else if (dsel < 9)
			r.delay_ms = $urandom_range(7, 40);
		else
			r.delay_ms = $urandom;
		if (pick < 50) begin
			r.kind = KIND_TICK;
		end else if (pick < 76) begin
			r.kind = KIND_SET;
		end else if (pick < 90) begin
			r.kind = KIND_CLEAR;
		end else if (pick < 95) begin
			r.kind = KIND_UNUSED;
		end else begin
			r.kind = pick[0] ? KIND_SET : KIND_CLEAR;
			r.timer_id = 8'h00;
		end
		return r;
	endfunction

	// start stays high across back-to-back requests; only lowered for a gap
	task automatic send_request(input ostt_req_t r, input int unsigned gap_pct);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		int unsigned gap_pct;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_req(KIND_TICK,   8'h00, 32'h0000_0000), 0);
		send_request(make_req(KIND_SET,    8'h00, 32'h0000_0005), 0);
		send_request(make_req(KIND_CLEAR,  8'h00, 32'h0000_0000), 0);
		send_request(make_req(KIND_CLEAR,  8'h09, 32'h0000_0000), 0);
		send_request(make_req(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF), 0);
		send_request(make_req(KIND_SET,    8'h01, 32'h0000_0000), 0);
		send_request(make_req(KIND_TICK,   8'h00, 32'h0000_0000), 0);
		send_request(make_req(KIND_SET,    8'hFF, 32'hFFFF_FFFF), 0);
		send_request(make_req(KIND_SET,    8'h10, 32'h0000_0002), 0);
		send_request(make_req(KIND_SET,    8'h20, 32'h0000_0002), 0);
		send_request(make_req(KIND_SET,    8'h30, 32'h0000_0002), 0);
		// table full: new id dropped, existing id re-armed
		send_request(make_req(KIND_SET,    8'h40, 32'h0000_0001), 0);
		send_request(make_req(KIND_SET,    8'h20, 32'h0000_0001), 0);
		send_request(make_req(KIND_TICK,   8'h00, 32'h0000_0000), 0);
		send_request(make_req(KIND_TICK,   8'h00, 32'h0000_0000), 0);
		send_request(make_req(KIND_CLEAR,  8'hFF, 32'h0000_0000), 0);
		// four timers expiring on the same tick
		send_request(make_req(KIND_SET,    8'h55, 32'h0000_0002), 0);
		send_request(make_req(KIND_SET,    8'hAA, 32'h0000_0002), 0);
		send_request(make_req(KIND_SET,    8'h0F, 32'h0000_0002), 0);
		send_request(make_req(KIND_SET,    8'hF0, 32'h0000_0002), 0);
		send_request(make_req(KIND_TICK,   8'h00, 32'h0000_0000), 0);
		send_request(make_req(KIND_TICK,   8'h00, 32'h0000_0000), 0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i < RANDOM_ITEMS / 3)
				gap_pct = 34;
			else if (i < 2 * RANDOM_ITEMS / 3)
				gap_pct = 74;
			else
				gap_pct = 0;
			send_request(random_request(), gap_pct);
		end
		start <= 1'b0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SLOTS + 6) @(posedge clk);

		if (sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
